FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// SSORT_ASSERT checks a property on every rising clock edge outside reset.
// SSORT_ASSERT_NEVER checks that an expression is never true outside reset.
// Defining ASSERT_OFF compiles both away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define SSORT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SSORT_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define SSORT_ASSERT(lbl, clk, rstn, prop, msg)
`define SSORT_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

FILE: rtl/ssort_pkg.sv
// ----------------------------------------------------------------------------
// ssort_pkg
// Shared constants, gap table and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package ssort_pkg;

  localparam int unsigned SSORT_DEPTH = 1024;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned GAP_W       = 4;
  localparam int unsigned GAP_NUM     = 4;
  localparam int unsigned GIDX_W      = 2;

  localparam logic [GAP_W-1:0] GAP_TABLE [GAP_NUM] = '{4'd9, 4'd5, 4'd3, 4'd1};

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_PULL = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic push;        // store value_i at the fill position
    logic sort_start;  // select the first gap
    logic pull_rd;     // read entry at the read pointer
    logic pull_out;    // load the result register
    logic gap_load;    // i = gap, read store[gap]
    logic load_x;      // latch x, j = i - gap, read store[j]
    logic shift;       // store[hole] = store[j], hole = j, read store[j - gap]
    logic place;       // store[hole] = x
    logic next_i;      // i = i + 1, read store[i + 1]
    logic next_gap;    // move to the next gap
    logic sort_done;   // set is sorted, rewind read pointer
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic gap_lt_count;
    logic last_gap;
    logic x_lt;
    logic j_ge_gap;
    logic next_lt_count;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/ssort_ram.sv
// ----------------------------------------------------------------------------
// ssort_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ssort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/ssort_dp.sv
// ----------------------------------------------------------------------------
// ssort_dp
// Sort datapath: value store, fill count, read pointer, insertion indexes
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ssort_dp import ssort_pkg::*; #(
  parameter int unsigned DEPTH = SSORT_DEPTH
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic signed [DATA_W-1:0]  value_i,
  input  wire cmd_t                      cmd_i,
  output sts_t                           sts_o,
  output logic signed [DATA_W-1:0]       sorted_value_o,
  output logic                           final_res_o,
  output logic                           empty_res_o,
  output logic                           overflow_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > GAP_W) ? CW : GAP_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            rp_q, rp_d;
  logic                     sorted_q, sorted_d;
  logic                     dropped_q, dropped_d;
  logic [GIDX_W-1:0]        gidx_q, gidx_d;
  logic [AW-1:0]            i_q, j_q, hole_q;
  logic signed [DATA_W-1:0] x_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic                     out_final_q, out_empty_q, out_ovf_q;

  logic [GAP_W-1:0]         gap;
  logic [AW-1:0]            gap_a;
  logic [CW-1:0]            cnt_eff;
  logic                     full;
  logic                     rd_empty;

  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [DATA_W-1:0]        ram_wdata, ram_rdata;
  logic signed [DATA_W-1:0] rd_val;

  assign gap      = GAP_TABLE[gidx_q];
  assign gap_a    = AW'(gap);
  assign cnt_eff  = sorted_q ? '0 : count_q;
  assign full     = (cnt_eff == DEPTH_C);
  assign rd_empty = !sorted_q || (rp_q >= count_q);
  assign rd_val   = $signed(ram_rdata);

  assign sts_o.gap_lt_count  = XW'(gap) < XW'(count_q);
  assign sts_o.last_gap      = (gidx_q == GIDX_W'(GAP_NUM - 1));
  assign sts_o.x_lt          = x_q < rd_val;
  assign sts_o.j_ge_gap      = XW'(j_q) >= XW'(gap);
  assign sts_o.next_lt_count = (CW'(i_q) + CW'(1)) < count_q;

  // memory port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hole_q;
    ram_wdata = x_q;
    if (cmd_i.push) begin
      ram_we    = !full;
      ram_waddr = cnt_eff[AW-1:0];
      ram_wdata = value_i;
    end else if (cmd_i.shift) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
    end else if (cmd_i.place) begin
      ram_we    = 1'b1;
    end
  end

  always_comb begin
    ram_re    = 1'b1;
    ram_raddr = rp_q[AW-1:0];
    if (cmd_i.gap_load) begin
      ram_raddr = gap_a;
    end else if (cmd_i.load_x) begin
      ram_raddr = i_q - gap_a;
    end else if (cmd_i.shift) begin
      ram_raddr = j_q - gap_a;
    end else if (cmd_i.next_i) begin
      ram_raddr = i_q + AW'(1);
    end else if (!cmd_i.pull_rd) begin
      ram_re = 1'b0;
    end
  end

  ssort_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // set bookkeeping
  always_comb begin
    count_d   = count_q;
    rp_d      = rp_q;
    sorted_d  = sorted_q;
    dropped_d = dropped_q;
    gidx_d    = gidx_q;
    if (cmd_i.push) begin
      // a push after a sort opens a new set
      count_d   = full ? cnt_eff : cnt_eff + CW'(1);
      dropped_d = (dropped_q && !sorted_q) || full;
      sorted_d  = 1'b0;
      if (sorted_q) begin
        rp_d = '0;
      end
    end
    if (cmd_i.sort_start) begin
      gidx_d = '0;
    end
    if (cmd_i.next_gap) begin
      gidx_d = gidx_q + GIDX_W'(1);
    end
    if (cmd_i.sort_done) begin
      sorted_d = 1'b1;
      rp_d     = '0;
    end
    if (cmd_i.pull_out && !rd_empty) begin
      rp_d = rp_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rp_q      <= '0;
      sorted_q  <= 1'b0;
      dropped_q <= 1'b0;
      gidx_q    <= '0;
    end else begin
      count_q   <= count_d;
      rp_q      <= rp_d;
      sorted_q  <= sorted_d;
      dropped_q <= dropped_d;
      gidx_q    <= gidx_d;
    end
  end

  // insertion indexes and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.gap_load) begin
      i_q <= gap_a;
    end
    if (cmd_i.next_i) begin
      i_q <= i_q + AW'(1);
    end
    if (cmd_i.load_x) begin
      x_q    <= rd_val;
      j_q    <= i_q - gap_a;
      hole_q <= i_q;
    end
    if (cmd_i.shift) begin
      hole_q <= j_q;
      j_q    <= j_q - gap_a;
    end
    if (cmd_i.pull_out) begin
      out_value_q <= rd_empty ? '0 : rd_val;
      out_final_q <= !rd_empty && ((rp_q + CW'(1)) == count_q);
      out_empty_q <= rd_empty;
      out_ovf_q   <= dropped_q;
    end
  end

  assign sorted_value_o = out_value_q;
  assign final_res_o    = out_final_q;
  assign empty_res_o    = out_empty_q;
  assign overflow_o     = out_ovf_q;

  `SSORT_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > DEPTH_C, "fill count past depth")
  `SSORT_ASSERT(a_rp_bound, clk_i, rst_ni, sorted_q |-> (rp_q <= count_q), "read pointer past set")
  `SSORT_ASSERT(a_i_bound, clk_i, rst_ni, cmd_i.load_x |-> (CW'(i_q) < count_q), "insert index out of set")

endmodule

`default_nettype wire

FILE: rtl/ssort_ctrl.sv
// ----------------------------------------------------------------------------
// ssort_ctrl
// Sequencer: request handshake, result valid and the gapped insertion walk.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ssort_ctrl import ssort_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic action_i,
  input  wire logic last_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PULL,
    ST_GAP,
    ST_LDX,
    ST_CMP,
    ST_WRX,
    ST_NEXT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  // a pull needs the result register free by the time its data returns
  assign in_ready_o = (state_q == ST_IDLE) &&
                      ((action_i == ACT_PUSH) || !out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (action_i == ACT_PULL) begin
            cmd_o.pull_rd = 1'b1;
            state_d       = ST_PULL;
          end else begin
            cmd_o.push = 1'b1;
            if (last_i) begin
              cmd_o.sort_start = 1'b1;
              state_d          = ST_GAP;
            end
          end
        end
      end
      ST_PULL: begin
        cmd_o.pull_out = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_GAP: begin
        if (sts_i.gap_lt_count) begin
          cmd_o.gap_load = 1'b1;
          state_d        = ST_LDX;
        end else if (sts_i.last_gap) begin
          cmd_o.sort_done = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.next_gap = 1'b1;
        end
      end
      ST_LDX: begin
        cmd_o.load_x = 1'b1;
        state_d      = ST_CMP;
      end
      ST_CMP: begin
        if (sts_i.x_lt) begin
          cmd_o.shift = 1'b1;
          state_d     = sts_i.j_ge_gap ? ST_CMP : ST_WRX;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = ST_NEXT;
        end
      end
      ST_WRX: begin
        cmd_o.place = 1'b1;
        state_d     = ST_NEXT;
      end
      ST_NEXT: begin
        if (sts_i.next_lt_count) begin
          cmd_o.next_i = 1'b1;
          state_d      = ST_LDX;
        end else if (sts_i.last_gap) begin
          cmd_o.sort_done = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.next_gap = 1'b1;
          state_d        = ST_GAP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.pull_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SSORT_ASSERT(a_pull_slot_free, clk_i, rst_ni, (state_q == ST_PULL) |-> !out_valid_q, "result register busy on pull")
  `SSORT_ASSERT(a_cmp_entry, clk_i, rst_ni, (state_q == ST_CMP) |-> ($past(state_q) == ST_LDX || $past(state_q) == ST_CMP), "compare entered out of order")
  `SSORT_ASSERT(a_valid_source, clk_i, rst_ni, $rose(out_valid_q) |-> ($past(state_q) == ST_PULL), "result without pull")

endmodule

`default_nettype wire

FILE: rtl/shell_sort_fixed_gaps_top.sv
// ----------------------------------------------------------------------------
// shell_sort_fixed_gaps_top
// Collects signed values, Shell sorts them with gaps 9, 5, 3, 1 and returns
// them in ascending order, one per pull request.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | in_valid_i, in_ready_o | action_i, value_i, last_i
//  out     | out_valid_o, out_ready_i | sorted_value_o, final_res_o,
//          |                        | empty_res_o, overflow_o
//
// A pull goes through a registered store read and gives one result per pull,
// held in an output register.
// A push with last starts the sort, whose pace per gap is bounded by the
// single read and write port of the store.
// in_ready_o is low while sorting, and for a pull while a result waits.
// Reset is asynchronous active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_sort_fixed_gaps_top import ssort_pkg::*; #(
  parameter int unsigned DEPTH = SSORT_DEPTH
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     action_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire logic                     last_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [DATA_W-1:0]      sorted_value_o,
  output logic                          final_res_o,
  output logic                          empty_res_o,
  output logic                          overflow_o
);

  cmd_t cmd;
  sts_t sts;

  ssort_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ssort_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sorted_value_o (sorted_value_o),
    .final_res_o    (final_res_o),
    .empty_res_o    (empty_res_o),
    .overflow_o     (overflow_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for shell_sort_fixed_gaps_top. A shadow of the sorter
// tracks fill, sort and read-out, and predicts every pull result. A short
// directed table runs first. Random sets of mixed sizes with noise pulls and
// abandoned read-outs follow. The run ends with one set that overruns the
// store. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import ssort_pkg::*;

  localparam int unsigned DEPTH       = SSORT_DEPTH;
  localparam int          STALL_LIMIT = 4000000;  // above a worst-case 1024-value sort
  localparam int          GAPS [4]    = '{9, 5, 3, 1};

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              fin;
    logic              emp;
    logic              ovf;
  } pull_res_t;

  typedef struct packed {
    logic      act;
    logic [DATA_W-1:0] val;
    logic      lst;
    logic      typed;   // res below is the expected result, else use the shadow
    pull_res_t res;
  } row_t;

  localparam row_t DIR_TAB [25] = '{
    '{ACT_PULL, 32'h1234_5678, 1'b0, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b0}},
    '{ACT_PUSH, 32'h8000_0000, 1'b0, 1'b0, '0},
    '{ACT_PUSH, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{ACT_PUSH, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{ACT_PUSH, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{ACT_PUSH, 32'h0000_0001, 1'b0, 1'b0, '0},
    '{ACT_PUSH, 32'hAAAA_AAAA, 1'b0, 1'b0, '0},
    '{ACT_PUSH, 32'h5555_5555, 1'b0, 1'b0, '0},
    '{ACT_PUSH, 32'h0000_0007, 1'b1, 1'b0, '0},
    '{ACT_PULL, 32'hFFFF_FFFF, 1'b1, 1'b1, '{32'h8000_0000, 1'b0, 1'b0, 1'b0}},
    '{ACT_PULL, 32'h0,         1'b0, 1'b0, '0},
    '{ACT_PULL, 32'h0,         1'b1, 1'b0, '0},
    '{ACT_PULL, 32'h0,         1'b0, 1'b0, '0},
    '{ACT_PULL, 32'h0,         1'b0, 1'b0, '0},
    '{ACT_PULL, 32'h0,         1'b0, 1'b0, '0},
    '{ACT_PULL, 32'h0,         1'b0, 1'b0, '0},
    '{ACT_PULL, 32'h0,         1'b0, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0}},
    '{ACT_PULL, 32'h0,         1'b0, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b0}},
    // push after a sort opens a new set
    '{ACT_PUSH, 32'h0000_0005, 1'b1, 1'b0, '0},
    '{ACT_PULL, 32'h0,         1'b0, 1'b1, '{32'h5, 1'b1, 1'b0, 1'b0}},
    '{ACT_PUSH, 32'h0000_0003, 1'b0, 1'b0, '0},
    // set still open, nothing to read
    '{ACT_PULL, 32'h0,         1'b0, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b0}},
    '{ACT_PUSH, 32'hFFFF_FFFE, 1'b1, 1'b0, '0},
    '{ACT_PULL, 32'h0,         1'b0, 1'b0, '0},
    '{ACT_PULL, 32'h0,         1'b0, 1'b0, '0}
  };

  logic                     clk_i     = 1'b0;
  logic                     rst_ni    = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     action    = ACT_PUSH;
  logic signed [DATA_W-1:0] value     = '0;
  logic                     last      = 1'b0;
  logic                     out_ready = 1'b0;
  logic                     in_ready;
  logic                     out_valid;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     final_res;
  logic                     empty_res;
  logic                     overflow;

  shell_sort_fixed_gaps_top #(.DEPTH(DEPTH)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (action),
    .value_i       (value),
    .last_i        (last),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .sorted_value_o(sorted_value),
    .final_res_o   (final_res),
    .empty_res_o   (empty_res),
    .overflow_o    (overflow)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the sorter
  logic signed [DATA_W-1:0] sh_mem [DEPTH];
  int unsigned sh_fill, sh_rd;
  bit          sh_sorted, sh_lost;

  pull_res_t expected_pull_q [$];
  int        err_cnt, req_cnt, rx_cnt, sort_cnt, drop_cnt, max_set;
  int        tx_idle_max = 19;
  int        rx_idle_max = 19;
  int        stall_cnt;

  function automatic void shell_sort_shadow();
    logic signed [DATA_W-1:0] x;
    int j, gap;
    for (int g = 0; g < 4; g++) begin
      gap = GAPS[g];
      for (int i = gap; i < int'(sh_fill); i++) begin
        x = sh_mem[i];
        j = i - gap;
        while (j >= 0 && x < sh_mem[j]) begin
          sh_mem[j + gap] = sh_mem[j];
          j -= gap;
        end
        sh_mem[j + gap] = x;
      end
    end
  endfunction

  function automatic void apply_push(logic [DATA_W-1:0] v, logic l);
    if (sh_sorted) begin
      sh_fill   = 0;
      sh_rd     = 0;
      sh_sorted = 1'b0;
      sh_lost   = 1'b0;
    end
    if (sh_fill < DEPTH) begin
      sh_mem[sh_fill] = v;
      sh_fill++;
    end else begin
      sh_lost = 1'b1;
      drop_cnt++;
    end
    if (l) begin
      shell_sort_shadow();
      sh_sorted = 1'b1;
      sh_rd     = 0;
      sort_cnt++;
    end
  endfunction

  function automatic pull_res_t apply_pull();
    pull_res_t r;
    if (!sh_sorted || sh_rd >= sh_fill) begin
      r = '{'0, 1'b0, 1'b1, sh_lost};
    end else begin
      r = '{sh_mem[sh_rd], sh_rd + 1 == sh_fill, 1'b0, sh_lost};
      sh_rd++;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] draw_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2:    return DATA_W'($urandom_range(0, 16)) - DATA_W'(8);  // duplicates
      default: return $urandom;
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    err_cnt++;
    $display("%s", msg);
  endtask

  // drive one request and hold it until accepted; the shadow moves on acceptance
  task automatic send_req(logic a, logic [DATA_W-1:0] v, logic l, logic typed,
                          pull_res_t typed_res);
    int gap;
    pull_res_t r;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    action   <= a;
    value    <= v;
    last     <= l;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    req_cnt++;
    if (a == ACT_PUSH) begin
      apply_push(v, l);
    end else begin
      r = apply_pull();
      expected_pull_q.push_back(typed ? typed_res : r);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_pull_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    int n_vals, n_pulls, start_reqs;
    bit with_last;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DIR_TAB[r]) begin
      send_req(DIR_TAB[r].act, DIR_TAB[r].val, DIR_TAB[r].lst, DIR_TAB[r].typed,
               DIR_TAB[r].res);
    end
    drain_results();

    start_reqs = req_cnt;
    while (req_cnt - start_reqs < 1000) begin
      case ($urandom_range(0, 2))
        0:       tx_idle_max = 0;
        1:       tx_idle_max = 4;
        default: tx_idle_max = 19;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: n_vals = $urandom_range(1, 12);
        6, 7, 8:          n_vals = $urandom_range(13, 40);
        default:          n_vals = $urandom_range(41, 160);
      endcase
      if (n_vals > max_set) max_set = n_vals;
      with_last = ($urandom_range(0, 15) != 0);
      for (int k = 0; k < n_vals; k++) begin
        if ($urandom_range(0, 15) == 0) send_req(ACT_PULL, $urandom, 1'($urandom), 1'b0, '0);
        send_req(ACT_PUSH, draw_value(), with_last && k == n_vals - 1, 1'b0, '0);
      end
      // mostly read the set out and a bit past; sometimes abandon it early
      if ($urandom_range(0, 7) == 0) n_pulls = $urandom_range(0, n_vals);
      else n_pulls = n_vals + $urandom_range(0, 2);
      for (int k = 0; k < n_pulls; k++) send_req(ACT_PULL, $urandom, 1'($urandom), 1'b0, '0);
    end
    drain_results();

    // overrun the store; the sort is started by a dropped push
    tx_idle_max = 2;
    for (int k = 0; k < DEPTH + 2; k++) begin
      send_req(ACT_PUSH, draw_value(), k == DEPTH + 1, 1'b0, '0);
    end
    for (int k = 0; k <= DEPTH; k++) send_req(ACT_PULL, $urandom, 1'($urandom), 1'b0, '0);
    drain_results();
    repeat (50) @(posedge clk_i);

    $display("covered %0d requests, %0d pull results, %0d sorted sets, %0d dropped pushes",
             req_cnt, rx_cnt, sort_cnt, drop_cnt);
    $display("random sets up to %0d values, plus one set past the %0d-entry store",
             max_set, DEPTH);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // result side
  initial begin
    pull_res_t want;
    int gap, hold_mark;
    hold_mark = 100;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      // long hold-off so the result register backs up into the request side
      if (rx_cnt == hold_mark) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_mark += 600;
      end
      if (rx_cnt % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       rx_idle_max = 0;
          1:       rx_idle_max = 5;
          default: rx_idle_max = 19;
        endcase
      end
      gap = $urandom_range(0, rx_idle_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      if (expected_pull_q.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with no pull pending", rx_cnt));
      end else begin
        want = expected_pull_q.pop_front();
        if (sorted_value !== want.value || final_res !== want.fin ||
            empty_res !== want.emp || overflow !== want.ovf) begin
          flag_mismatch($sformatf(
            "result %0d: got value %0d final %b empty %b ovf %b, want %0d %b %b %b",
            rx_cnt, sorted_value, final_res, empty_res, overflow,
            $signed(want.value), want.fin, want.emp, want.ovf));
        end
      end
      rx_cnt++;
    end
  end

  // watchdog on cycles where neither channel moves
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
